### rtl/abdi_pkg.sv
`timescale 1ns / 1ps

package abdi_pkg;

    // Fixed field widths
    localparam int SAMPLE_W    = 16;
    localparam int CORR_W      = 17;
    localparam int SPEED_OUT_W = 32;
    localparam int DIST_OUT_W  = 48;
    localparam int CAL_W       = 11;
    localparam int MAX_AXES    = 3;

    // Divider steps: one quotient bit per cycle, quotient magnitude fits a sample
    localparam int DIV_CNT_W = $clog2(SAMPLE_W);

    // Register file
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [CAL_W-1:0] CAL_SAMPLES_RST = CAL_W'(64);

    // Parameter defaults
    localparam int AXES_DEF            = 3;
    localparam int MAX_CAL_SAMPLES_DEF = 1024;
    localparam int SPEED_BITS_DEF      = 32;
    localparam int DISTANCE_BITS_DEF   = 48;

    typedef enum logic [1:0] {
        CMD_INTEGRATE = 2'd0,
        CMD_CALIBRATE = 2'd1,
        CMD_LOAD_BIAS = 2'd2,
        CMD_NONE      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_CALIB_SAMPLES = 2'd0,
        REG_BIAS_X        = 2'd1,
        REG_BIAS_Y        = 2'd2,
        REG_BIAS_Z        = 2'd3
    } t_reg_idx;

    // Sequencer to lanes
    typedef struct packed {
        logic accept;
        t_cmd cmd;
        logic speed_en;
        logic dist_en;
        logic div_start;
        logic div_step;
        logic div_finish;
    } t_lane_ctrl;

endpackage

### rtl/abdi_div.sv
`timescale 1ns / 1ps

// Restoring divider, signed dividend by unsigned divisor, truncates toward zero.
// Quotient magnitude must fit SAMPLE_W bits (true for an average of samples).
module abdi_div #(
    parameter int CNT_W = 11
) (
    input  logic                                      i_clk,
    input  logic                                      i_start,
    input  logic                                      i_step,
    input  logic signed [abdi_pkg::SAMPLE_W+CNT_W-1:0] i_dividend,
    input  logic        [CNT_W-1:0]                   i_divisor,
    output logic signed [abdi_pkg::SAMPLE_W-1:0]      o_quot
);

    localparam int QW    = abdi_pkg::SAMPLE_W;
    localparam int SUM_W = QW + CNT_W;

    logic             r_neg;
    logic [CNT_W-1:0] r_rem;
    logic [QW-1:0]    r_q;

    logic [SUM_W-1:0] w_mag;
    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_diff;
    logic             w_ge;

    assign w_mag   = i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_trial = {r_rem, r_q[QW-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_rem <= w_mag[SUM_W-1:QW];
            r_q   <= w_mag[QW-1:0];
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_quot = r_neg ? (~r_q + 1'b1) : r_q;

endmodule

### rtl/abdi_lane.sv
`timescale 1ns / 1ps

// One axis: bias, speed and distance accumulators, calibration sum, divider.
module abdi_lane #(
    parameter int CNT_W         = 11,
    parameter int SPEED_BITS    = abdi_pkg::SPEED_BITS_DEF,
    parameter int DISTANCE_BITS = abdi_pkg::DISTANCE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  abdi_pkg::t_lane_ctrl                  i_ctrl,
    input  logic signed [abdi_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic signed [abdi_pkg::SAMPLE_W-1:0]  i_manual_bias,
    input  logic        [CNT_W-1:0]               i_divisor,
    output logic signed [abdi_pkg::CORR_W-1:0]    o_corrected,
    output logic signed [SPEED_BITS-1:0]          o_speed,
    output logic signed [DISTANCE_BITS-1:0]       o_distance
);

    localparam int SW    = abdi_pkg::SAMPLE_W;
    localparam int SUM_W = SW + CNT_W;

    logic signed [SW-1:0]            r_last,  n_last;
    logic signed [SW-1:0]            r_bias,  n_bias;
    logic signed [SPEED_BITS-1:0]    r_speed, n_speed;
    logic signed [DISTANCE_BITS-1:0] r_dist,  n_dist;
    logic signed [SUM_W-1:0]         r_sum,   n_sum;

    logic signed [abdi_pkg::CORR_W-1:0] w_corr;
    logic signed [SW-1:0]               w_quot;

    assign w_corr = abdi_pkg::CORR_W'(r_last) - abdi_pkg::CORR_W'(r_bias);

    abdi_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_start    (i_ctrl.div_start),
        .i_step     (i_ctrl.div_step),
        .i_dividend (r_sum),
        .i_divisor  (i_divisor),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_last  = r_last;
        n_bias  = r_bias;
        n_speed = r_speed;
        n_dist  = r_dist;
        n_sum   = r_sum;
        if (i_ctrl.accept) begin
            unique case (i_ctrl.cmd)
                abdi_pkg::CMD_INTEGRATE: begin
                    n_last = i_sample;
                end
                abdi_pkg::CMD_CALIBRATE: begin
                    n_last = i_sample;
                    n_sum  = r_sum + SUM_W'(i_sample);
                end
                abdi_pkg::CMD_LOAD_BIAS: begin
                    n_bias = i_manual_bias;
                end
                abdi_pkg::CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end
        if (i_ctrl.speed_en) begin
            n_speed = r_speed + SPEED_BITS'(w_corr);
        end
        if (i_ctrl.dist_en) begin
            n_dist = r_dist + DISTANCE_BITS'(r_speed);
        end
        if (i_ctrl.div_start) begin
            n_sum = '0;
        end
        if (i_ctrl.div_finish) begin
            n_bias  = w_quot;
            n_speed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_bias  <= '0;
            r_speed <= '0;
            r_dist  <= '0;
            r_sum   <= '0;
        end else begin
            r_last  <= n_last;
            r_bias  <= n_bias;
            r_speed <= n_speed;
            r_dist  <= n_dist;
            r_sum   <= n_sum;
        end
    end

    assign o_corrected = w_corr;
    assign o_speed     = r_speed;
    assign o_distance  = r_dist;

endmodule

### rtl/abdi_regs.sv
`timescale 1ns / 1ps

// APB register file: calibration length and manual bias per axis.
module abdi_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [abdi_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [abdi_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [abdi_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    output logic [abdi_pkg::CAL_W-1:0]             o_cal_samples,
    output logic signed [abdi_pkg::SAMPLE_W-1:0]   o_manual_bias [abdi_pkg::MAX_AXES]
);

    localparam int DW = abdi_pkg::APB_DATA_W;
    localparam int SW = abdi_pkg::SAMPLE_W;

    logic [abdi_pkg::CAL_W-1:0] r_cal;
    logic signed [SW-1:0]       r_bias [abdi_pkg::MAX_AXES];
    abdi_pkg::t_reg_idx         w_idx;
    logic                       w_wr;

    assign w_idx  = abdi_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal     <= abdi_pkg::CAL_SAMPLES_RST;
            r_bias[0] <= '0;
            r_bias[1] <= '0;
            r_bias[2] <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                abdi_pkg::REG_CALIB_SAMPLES: r_cal     <= pwdata[abdi_pkg::CAL_W-1:0];
                abdi_pkg::REG_BIAS_X:        r_bias[0] <= pwdata[SW-1:0];
                abdi_pkg::REG_BIAS_Y:        r_bias[1] <= pwdata[SW-1:0];
                abdi_pkg::REG_BIAS_Z:        r_bias[2] <= pwdata[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            abdi_pkg::REG_CALIB_SAMPLES: prdata = DW'(r_cal);
            abdi_pkg::REG_BIAS_X:        prdata = {{(DW-SW){1'b0}}, r_bias[0]};
            abdi_pkg::REG_BIAS_Y:        prdata = {{(DW-SW){1'b0}}, r_bias[1]};
            abdi_pkg::REG_BIAS_Z:        prdata = {{(DW-SW){1'b0}}, r_bias[2]};
            default:                     prdata = '0;
        endcase
    end

    assign o_cal_samples = r_cal;
    assign o_manual_bias = r_bias;

endmodule

### rtl/accel_bias_double_integrator.sv
`timescale 1ns / 1ps

// Accelerometer bias removal and double integration over up to three axes. Each
// input word carries a command and one signed sample per axis, and yields exactly
// one result word with the corrected acceleration, speed and distance per axis.
// Integrate subtracts the axis bias, adds it to a wrapping speed accumulator and
// then adds the new speed to a wrapping distance accumulator. Calibrate sums
// samples; once calib_samples of them are in, each bias becomes sum / count
// (truncated toward zero), speed is cleared and calibration_done is set. Load
// bias copies the manual bias registers. Words are handled one at a time: an
// integrate word passes through a speed and then a distance update, calibrate
// and load-bias words skip the distance update, and a word that completes a
// calibration first runs the 16-step restoring divider in each axis lane.
// Registers sit on an APB port at byte addresses 0, 4, 8, 12.
module accel_bias_double_integrator #(
    parameter int AXES            = abdi_pkg::AXES_DEF,
    parameter int MAX_CAL_SAMPLES = abdi_pkg::MAX_CAL_SAMPLES_DEF,
    parameter int SPEED_BITS      = abdi_pkg::SPEED_BITS_DEF,
    parameter int DISTANCE_BITS   = abdi_pkg::DISTANCE_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // APB configuration
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [abdi_pkg::APB_ADDR_W-1:0]          paddr,
    input  logic [abdi_pkg::APB_DATA_W-1:0]          pwdata,
    output logic [abdi_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready,
    // input words
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [1:0]                               i_command,
    input  logic signed [abdi_pkg::SAMPLE_W-1:0]     i_sample_x,
    input  logic signed [abdi_pkg::SAMPLE_W-1:0]     i_sample_y,
    input  logic signed [abdi_pkg::SAMPLE_W-1:0]     i_sample_z,
    // result words
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic signed [abdi_pkg::CORR_W-1:0]       o_corrected_x,
    output logic signed [abdi_pkg::CORR_W-1:0]       o_corrected_y,
    output logic signed [abdi_pkg::CORR_W-1:0]       o_corrected_z,
    output logic signed [abdi_pkg::SPEED_OUT_W-1:0]  o_speed_x,
    output logic signed [abdi_pkg::SPEED_OUT_W-1:0]  o_speed_y,
    output logic signed [abdi_pkg::SPEED_OUT_W-1:0]  o_speed_z,
    output logic signed [abdi_pkg::DIST_OUT_W-1:0]   o_distance_x,
    output logic signed [abdi_pkg::DIST_OUT_W-1:0]   o_distance_y,
    output logic signed [abdi_pkg::DIST_OUT_W-1:0]   o_distance_z,
    output logic                                     o_calibration_done
);

    localparam int NA    = abdi_pkg::MAX_AXES;
    localparam int SW    = abdi_pkg::SAMPLE_W;
    localparam int CW    = abdi_pkg::CORR_W;
    localparam int SOW   = abdi_pkg::SPEED_OUT_W;
    localparam int DOW   = abdi_pkg::DIST_OUT_W;
    localparam int CAL_W = abdi_pkg::CAL_W;
    localparam int DCW   = abdi_pkg::DIV_CNT_W;
    // count reaches MAX_CAL_SAMPLES at most
    localparam int CNT_W = $clog2(MAX_CAL_SAMPLES + 1);
    localparam int TGT_W = (CNT_W > CAL_W) ? CNT_W : CAL_W;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for a word
        S_SPEED,  // speed update, or divider load on calibration end
        S_DIST,   // distance update
        S_DIV,    // one quotient bit per cycle in every lane
        S_FIN,    // bias from quotient, speed cleared
        S_PUSH    // hand the result to the output register
    } t_state;

    t_state          r_state;
    abdi_pkg::t_cmd  r_cmd;
    logic            r_done;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_divisor;
    logic [DCW-1:0]  r_div_cnt;

    // output register
    logic                   r_out_valid;
    logic                   r_out_done;
    logic signed [CW-1:0]   r_out_corr  [NA];
    logic signed [SOW-1:0]  r_out_speed [NA];
    logic signed [DOW-1:0]  r_out_dist  [NA];

    // register file
    logic [CAL_W-1:0]       w_cal_samples;
    logic signed [SW-1:0]   w_manual_bias [NA];

    // lane results, zero for axes not built
    logic signed [SW-1:0]            w_sample [NA];
    logic signed [CW-1:0]            w_corr   [NA];
    logic signed [SPEED_BITS-1:0]    w_speed  [NA];
    logic signed [DISTANCE_BITS-1:0] w_dist   [NA];

    abdi_pkg::t_cmd       w_cmd;
    abdi_pkg::t_lane_ctrl w_ctrl;
    logic                 w_accept;
    logic                 w_out_free;
    logic [CNT_W-1:0]     w_count_inc;
    logic [TGT_W-1:0]     w_cfg_ext;
    logic [TGT_W-1:0]     w_target;
    logic                 w_cal_full;

    abdi_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_cal_samples (w_cal_samples),
        .o_manual_bias (w_manual_bias)
    );

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_cmd      = abdi_pkg::t_cmd'(i_command);

    // Calibration target: 0 acts as 1, clamp at MAX_CAL_SAMPLES.
    assign w_cfg_ext   = TGT_W'(w_cal_samples);
    assign w_count_inc = r_count + CNT_W'(1);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_target = TGT_W'(1);
        end else if (w_cfg_ext > TGT_W'(MAX_CAL_SAMPLES)) begin
            w_target = TGT_W'(MAX_CAL_SAMPLES);
        end else begin
            w_target = w_cfg_ext;
        end
    end
    assign w_cal_full = TGT_W'(w_count_inc) >= w_target;

    // lane control
    always_comb begin
        w_ctrl.accept     = w_accept;
        w_ctrl.cmd        = w_cmd;
        w_ctrl.speed_en   = (r_state == S_SPEED) && (r_cmd == abdi_pkg::CMD_INTEGRATE);
        w_ctrl.dist_en    = (r_state == S_DIST);
        w_ctrl.div_start  = (r_state == S_SPEED) && r_done;
        w_ctrl.div_step   = (r_state == S_DIV);
        w_ctrl.div_finish = (r_state == S_FIN);
    end

    assign w_sample[0] = i_sample_x;
    assign w_sample[1] = i_sample_y;
    assign w_sample[2] = i_sample_z;

    for (genvar g = 0; g < NA; g++) begin : g_lane
        if (g < AXES) begin : g_on
            abdi_lane #(
                .CNT_W         (CNT_W),
                .SPEED_BITS    (SPEED_BITS),
                .DISTANCE_BITS (DISTANCE_BITS)
            ) u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (w_ctrl),
                .i_sample      (w_sample[g]),
                .i_manual_bias (w_manual_bias[g]),
                .i_divisor     (r_divisor),
                .o_corrected   (w_corr[g]),
                .o_speed       (w_speed[g]),
                .o_distance    (w_dist[g])
            );
        end else begin : g_off
            assign w_corr[g]  = '0;
            assign w_speed[g] = '0;
            assign w_dist[g]  = '0;
        end
    end

    // sequencer, calibration count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd       <= abdi_pkg::CMD_NONE;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_divisor   <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_out_done  <= 1'b0;
        end else begin
            // output valid: set on push, cleared once taken
            if ((r_state == S_PUSH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= w_cmd;
                        r_done  <= (w_cmd == abdi_pkg::CMD_CALIBRATE) && w_cal_full;
                        r_state <= S_SPEED;
                        if (w_cmd == abdi_pkg::CMD_CALIBRATE) begin
                            if (w_cal_full) begin
                                r_divisor <= w_count_inc;
                                r_count   <= '0;
                            end else begin
                                r_count <= w_count_inc;
                            end
                        end
                    end
                end
                S_SPEED: begin
                    r_div_cnt <= '0;
                    if (r_cmd == abdi_pkg::CMD_INTEGRATE) begin
                        r_state <= S_DIST;
                    end else if (r_done) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_PUSH;
                    end
                end
                S_DIST: begin
                    r_state <= S_PUSH;
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + DCW'(1);
                    if (r_div_cnt == DCW'(SW - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    // merge lanes into the output word
                    if (w_out_free) begin
                        r_out_done  <= r_done;
                        for (int j = 0; j < NA; j++) begin
                            r_out_corr[j]  <= w_corr[j];
                            r_out_speed[j] <= SOW'(w_speed[j]);
                            r_out_dist[j]  <= DOW'(w_dist[j]);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_out_valid;
    assign o_calibration_done = r_out_done;
    assign o_corrected_x      = r_out_corr[0];
    assign o_corrected_y      = r_out_corr[1];
    assign o_corrected_z      = r_out_corr[2];
    assign o_speed_x          = r_out_speed[0];
    assign o_speed_y          = r_out_speed[1];
    assign o_speed_z          = r_out_speed[2];
    assign o_distance_x       = r_out_dist[0];
    assign o_distance_y       = r_out_dist[1];
    assign o_distance_z       = r_out_dist[2];

endmodule

### rtl/abdi_checker.sv
`timescale 1ns / 1ps

module abdi_checker (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    i_valid,
    input logic                                    o_stall,
    input logic                                    o_valid,
    input logic                                    i_stall,
    input logic signed [abdi_pkg::CORR_W-1:0]      o_corrected_x,
    input logic signed [abdi_pkg::SPEED_OUT_W-1:0] o_speed_x,
    input logic signed [abdi_pkg::SPEED_OUT_W-1:0] o_speed_y,
    input logic signed [abdi_pkg::SPEED_OUT_W-1:0] o_speed_z,
    input logic signed [abdi_pkg::DIST_OUT_W-1:0]  o_distance_x,
    input logic                                    o_calibration_done
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_corrected_x) && $stable(o_speed_x)
            && $stable(o_distance_x) && $stable(o_calibration_done))
        else $error("stalled result word changed");

    // one word in flight: accepting closes the input
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second word accepted while busy");

    // the result never appears in the cycle right after an accept
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result raised too early");

    // a finished calibration reports cleared speed
    a_cal_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_calibration_done |-> o_speed_x == '0 && o_speed_y == '0
            && o_speed_z == '0)
        else $error("speed not cleared on calibration end");

endmodule

bind accel_bias_double_integrator abdi_checker u_abdi_checker (.*);

### bench/tb_accel_bias_double_integrator.sv
`timescale 1ns / 1ps

module tb_accel_bias_double_integrator;
    import abdi_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;
    localparam int CAL_CEILING = 1024;   // MAX_CAL_SAMPLES of the instance

    // One input word: axis 0 is x, 1 is y, 2 is z
    typedef struct packed {
        t_cmd             cmd;
        logic [2:0][15:0] smp;
    } accel_word_t;

    // One result word, same axis order
    typedef struct packed {
        logic [2:0][16:0] corr;
        logic [2:0][31:0] spd;
        logic [2:0][47:0] dst;
        logic             done;
    } motion_t;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr   = '0;
    logic [APB_DATA_W-1:0]   pwdata  = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [1:0]              i_command  = '0;
    logic signed [SAMPLE_W-1:0] i_sample_x = '0;
    logic signed [SAMPLE_W-1:0] i_sample_y = '0;
    logic signed [SAMPLE_W-1:0] i_sample_z = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [CORR_W-1:0]      o_corrected_x, o_corrected_y, o_corrected_z;
    logic signed [SPEED_OUT_W-1:0] o_speed_x, o_speed_y, o_speed_z;
    logic signed [DIST_OUT_W-1:0]  o_distance_x, o_distance_y, o_distance_z;
    logic                    o_calibration_done;

    accel_bias_double_integrator uut (.*);

    // Stimulus waiting for the driver, and results waiting for the block
    accel_word_t words_to_send[$];
    motion_t     motion_due[$];

    // Predictor copy of the registers and the block state
    logic [CAL_W-1:0]   cal_target_reg;
    logic [15:0]        manual_bias_reg [3];
    logic signed [15:0] bias [3];
    logic [31:0]        speed [3];
    logic [47:0]        dist_acc [3];
    longint             cal_sum [3];
    int                 cal_count;
    logic signed [15:0] last_smp [3];

    // Idle control, set per phase by the sequencer below
    int send_idle_pct  = 0;
    int stall_idle_pct = 0;
    int mismatches     = 0;

    initial forever #5 i_clk = ~i_clk;

    // Predicts the result word for one accepted input word and advances the
    // predictor state exactly as the block does.
    function automatic motion_t advance_motion(accel_word_t w);
        motion_t            m;
        int                 target;
        logic signed [16:0] c;
        m = '0;
        case (w.cmd)
            CMD_INTEGRATE: begin
                for (int a = 0; a < 3; a++) begin
                    last_smp[a] = w.smp[a];
                    c = $signed({last_smp[a][15], last_smp[a]}) - $signed({bias[a][15], bias[a]});
                    speed[a] = speed[a] + {{15{c[16]}}, c};
                    dist_acc[a] = dist_acc[a] + {{16{speed[a][31]}}, speed[a]};
                end
            end
            CMD_CALIBRATE: begin
                // zero acts as one, anything past the ceiling is clamped
                target = int'(cal_target_reg);
                if (target < 1)
                    target = 1;
                if (target > CAL_CEILING)
                    target = CAL_CEILING;
                for (int a = 0; a < 3; a++) begin
                    last_smp[a] = w.smp[a];
                    cal_sum[a] = cal_sum[a] + last_smp[a];
                end
                cal_count++;
                // >= so a target lowered under the gathered count completes now
                if (cal_count >= target) begin
                    for (int a = 0; a < 3; a++) begin
                        bias[a] = 16'(cal_sum[a] / longint'(cal_count));  // toward zero
                        speed[a] = '0;
                        cal_sum[a] = 0;
                    end
                    cal_count = 0;
                    m.done = 1'b1;
                end
            end
            CMD_LOAD_BIAS: begin
                // samples ignored, last sample kept
                for (int a = 0; a < 3; a++)
                    bias[a] = manual_bias_reg[a];
            end
            default: begin
            end
        endcase
        for (int a = 0; a < 3; a++) begin
            m.corr[a] = $signed({last_smp[a][15], last_smp[a]}) - $signed({bias[a][15], bias[a]});
            m.spd[a]  = speed[a];
            m.dst[a]  = dist_acc[a];
        end
        return m;
    endfunction

    // APB write: setup cycle, access cycle; pready is tied high so the
    // register takes the value at the access edge.
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_CALIB_SAMPLES)
            cal_target_reg = value[CAL_W-1:0];
        else
            manual_bias_reg[int'(idx) - 1] = value[15:0];
    endtask

    task automatic queue_word(t_cmd cmd, logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
        accel_word_t w;
        w.cmd    = cmd;
        w.smp[0] = sx;
        w.smp[1] = sy;
        w.smp[2] = sz;
        words_to_send.push_back(w);
    endtask

    // Block idle: nothing queued, nothing offered, nothing outstanding.
    // Checked at the falling edge, after the driver and monitor have settled.
    task automatic wait_drained();
        while (words_to_send.size() != 0 || i_valid || motion_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Sample mix weighted toward the rails and small values around zero
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 512)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cmd pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return CMD_INTEGRATE;
        if (r < 80)
            return CMD_CALIBRATE;
        if (r < 93)
            return CMD_LOAD_BIAS;
        return CMD_NONE;
    endfunction

    task automatic check_field(string what, int axis, logic [47:0] want_v, logic [47:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s[%0d] expected %h, got %h", $realtime, what, axis,
                         want_v, got_v);
        end
    endtask

    // Driver: offers the next queued word, holds it while stalled, and after
    // an accept may back off for a random burst of idle cycles. The
    // prediction is made at the accept edge.
    int          send_gap = 0;
    accel_word_t word_now;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                motion_due.push_back(advance_motion(word_now));
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    word_now = words_to_send.pop_front();
                    i_command  <= word_now.cmd;
                    i_sample_x <= word_now.smp[0];
                    i_sample_y <= word_now.smp[1];
                    i_sample_z <= word_now.smp[2];
                    i_valid    <= 1'b1;
                    if ($urandom_range(99) < send_idle_pct)
                        send_gap = $urandom_range(1, 16);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word against the oldest
    // prediction and drives the result-side stall in random bursts.
    int stall_left = 0;

    always @(posedge i_clk) begin : result_check
        motion_t got;
        motion_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.corr = {o_corrected_z, o_corrected_y, o_corrected_x};
                got.spd  = {o_speed_z, o_speed_y, o_speed_x};
                got.dst  = {o_distance_z, o_distance_y, o_distance_x};
                got.done = o_calibration_done;
                if (motion_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result word with nothing expected", $realtime);
                end else begin
                    want = motion_due.pop_front();
                    for (int a = 0; a < 3; a++) begin
                        check_field("corrected", a, 48'(want.corr[a]), 48'(got.corr[a]));
                        check_field("speed", a, 48'(want.spd[a]), 48'(got.spd[a]));
                        check_field("distance", a, want.dst[a], got.dst[a]);
                    end
                    check_field("calibration_done", 0, 48'(want.done), 48'(got.done));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if ($urandom_range(99) < stall_idle_pct) begin
                stall_left = $urandom_range(0, 15);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++)
            @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // Sequencer: reset, directed words, random phases, then a long
    // calibration run with no idling on either side.
    initial begin
        int targets [8];
        int burst;
        targets = '{1, 2, 4, 8, 16, 3, 0, 12};

        // predictor matches the block's reset state
        cal_target_reg = CAL_SAMPLES_RST;
        cal_count = 0;
        for (int a = 0; a < 3; a++) begin
            manual_bias_reg[a] = '0;
            bias[a]     = '0;
            speed[a]    = '0;
            dist_acc[a] = '0;
            cal_sum[a]  = 0;
            last_smp[a] = '0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: rails through integrate, then the unused command
        queue_word(CMD_INTEGRATE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        queue_word(CMD_INTEGRATE, 16'h8000, 16'h8000, 16'h8000);
        queue_word(CMD_INTEGRATE, 16'h0000, 16'hFFFF, 16'h0001);
        queue_word(CMD_NONE, pick_sample(), pick_sample(), pick_sample());
        wait_drained();

        // rail biases; junk above bit 15 must be dropped
        write_reg(REG_CALIB_SAMPLES, 32'd3);
        write_reg(REG_BIAS_X, 32'h0000_7FFF);
        write_reg(REG_BIAS_Y, 32'h0000_8000);
        write_reg(REG_BIAS_Z, 32'hABCD_1234);
        // load-bias ignores its samples; corrected hits +/-65535 after it.
        // The calibration is interleaved with integrate, load-bias and the
        // unused command, and z averages -5/3, which must truncate to -1.
        queue_word(CMD_LOAD_BIAS, pick_sample(), pick_sample(), pick_sample());
        queue_word(CMD_INTEGRATE, 16'h8000, 16'h7FFF, 16'h0000);
        queue_word(CMD_CALIBRATE, 16'h7FFF, 16'h8000, 16'hFFF9);
        queue_word(CMD_INTEGRATE, pick_sample(), pick_sample(), pick_sample());
        queue_word(CMD_LOAD_BIAS, pick_sample(), pick_sample(), pick_sample());
        queue_word(CMD_CALIBRATE, 16'h7FFF, 16'h8000, 16'h0002);
        queue_word(CMD_NONE, pick_sample(), pick_sample(), pick_sample());
        queue_word(CMD_CALIBRATE, 16'h7FFF, 16'h8000, 16'h0000);
        queue_word(CMD_INTEGRATE, 16'h0000, 16'h0000, 16'h0000);
        wait_drained();

        // a target of zero completes on every calibration word
        write_reg(REG_CALIB_SAMPLES, 32'd0);
        for (int k = 0; k < 3; k++)
            queue_word(CMD_CALIBRATE, pick_sample(), pick_sample(), pick_sample());
        queue_word(CMD_INTEGRATE, pick_sample(), pick_sample(), pick_sample());
        wait_drained();

        // gather a few at the top target, then lower it under the count
        write_reg(REG_CALIB_SAMPLES, 32'd1024);
        for (int k = 0; k < 4; k++)
            queue_word(CMD_CALIBRATE, pick_sample(), pick_sample(), pick_sample());
        wait_drained();
        write_reg(REG_CALIB_SAMPLES, 32'hFFFF_F802);
        queue_word(CMD_CALIBRATE, pick_sample(), pick_sample(), pick_sample());
        queue_word(CMD_INTEGRATE, pick_sample(), pick_sample(), pick_sample());
        wait_drained();

        // random phases with varying targets, biases and idle pressure
        for (int ph = 0; ph < 8; ph++) begin
            if (ph[0])
                write_reg(REG_CALIB_SAMPLES, ($urandom & 32'hFFFF_F800) | targets[ph]);
            else
                write_reg(REG_CALIB_SAMPLES, targets[ph]);
            if (ph == 0) begin
                write_reg(REG_BIAS_X, 32'h0000_8000);
                write_reg(REG_BIAS_Y, 32'h0000_7FFF);
                write_reg(REG_BIAS_Z, 32'h0000_0000);
            end else begin
                write_reg(REG_BIAS_X, $urandom);
                write_reg(REG_BIAS_Y, $urandom);
                write_reg(REG_BIAS_Z, $urandom);
            end
            case (ph % 3)
                0: begin
                    send_idle_pct  = 0;
                    stall_idle_pct = 0;
                end
                1: begin
                    send_idle_pct  = 30;
                    stall_idle_pct = 30;
                end
                default: begin
                    send_idle_pct  = 10;
                    stall_idle_pct = 50;
                end
            endcase
            while (words_to_send.size() < 66) begin
                if ($urandom_range(9) < 3) begin
                    // calibration run with the odd integrate slipped in
                    burst = $urandom_range(1, 18);
                    for (int k = 0; k < burst; k++) begin
                        queue_word(CMD_CALIBRATE, pick_sample(), pick_sample(), pick_sample());
                        if ($urandom_range(4) == 0)
                            queue_word(CMD_INTEGRATE, pick_sample(), pick_sample(),
                                       pick_sample());
                    end
                end else begin
                    queue_word(pick_cmd(), pick_sample(), pick_sample(), pick_sample());
                end
            end
            wait_drained();
        end

        // last part, no idling: 2047 clamps to the ceiling, a long run at the
        // rails builds large sums, then a target lowered under the count
        // completes the calibration on the next word
        send_idle_pct  = 0;
        stall_idle_pct = 0;
        write_reg(REG_CALIB_SAMPLES, 32'h0000_07FF);
        write_reg(REG_BIAS_X, $urandom);
        write_reg(REG_BIAS_Y, $urandom);
        write_reg(REG_BIAS_Z, $urandom);
        for (int k = 0; k < 200; k++)
            queue_word(CMD_CALIBRATE, 16'h8000, 16'h7FFF, pick_sample());
        wait_drained();
        write_reg(REG_CALIB_SAMPLES, 32'd5);
        queue_word(CMD_CALIBRATE, 16'h8000, 16'h7FFF, pick_sample());
        for (int k = 0; k < 5; k++)
            queue_word(CMD_INTEGRATE, pick_sample(), pick_sample(), pick_sample());
        wait_drained();
        repeat (40) @(posedge i_clk);

        if (mismatches == 0 && motion_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/abdi_pkg.sv
rtl/abdi_div.sv
rtl/abdi_lane.sv
rtl/abdi_regs.sv
rtl/accel_bias_double_integrator.sv
rtl/abdi_checker.sv
bench/tb_accel_bias_double_integrator.sv
